### hw/rtl/double_ended_queue_assert.svh
// Assertion macros used by the checker file of the queue.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// General form: explicit clock and active-low reset.
`define DQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Short form for blocks that use the house clock and reset names.
`define DQ_ASSERT(lbl, prop, msg) \
  `DQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic signed [VAL_W-1:0]   push_value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]   popped_value;
    status_e                   status;
    logic        [CNT_W-1:0]   fill_count;
  } rsp_t;

  // Ring position that lies ofs places after base, wrapped into 0..DEPTH-1.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### hw/rtl/dq_req_if.sv
interface dq_req_if import dq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/dq_rsp_if.sv
interface dq_rsp_if import dq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values in a ring memory.
// The req channel carries one request per item: an action (push front,
// push back, pop front, pop back) and the value to push. The rsp channel
// returns exactly one result per request, in order: the popped value
// (zero on pushes and on failed pops), a status (ok, empty, full) and
// the number of entries held after the step.
// The result is registered and shows in the cycle after the request is
// accepted. Pointers are updated at acceptance and the single memory
// access (write for a push, registered read for a pop) happens at the
// same edge, so a new request can be taken every cycle while the result
// side keeps taking results. The result register holds one result; while
// it waits on rsp.ready, req.ready is low.
// Reset empties the queue and sets the front position to zero; the memory
// contents are not cleared and no clearing pass is needed, because an
// entry is only read after it has been written.
module double_ended_queue import dq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rsp_valid_q;
  status_e          status_q, status_d;
  logic [CNT_W-1:0] fill_q;
  logic             pop_ok_q, pop_ok_d;

  logic             accept;
  logic             full, empty;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = ST_OK;
    pop_ok_d = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = front_q;
    raddr    = front_q;
    unique case (req.data.action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          front_d = ring_add(front_q, IDX_W'(DEPTH - 1));
          waddr   = front_d;
          we      = accept;
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          waddr   = ring_add(front_q, count_q[IDX_W-1:0]);
          we      = accept;
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          raddr    = front_q;
          re       = accept;
          pop_ok_d = 1'b1;
          front_d  = ring_add(front_q, IDX_W'(1));
          count_d  = count_q - CNT_W'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d  = count_q - CNT_W'(1);
          raddr    = ring_add(front_q, count_d[IDX_W-1:0]);
          re       = accept;
          pop_ok_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // A push writes at the edge it is accepted, so a pop of the same entry
  // in any later cycle already reads the new value; no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= req.data.push_value;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= ST_OK;
      fill_q      <= '0;
      pop_ok_q    <= 1'b0;
    end else begin
      if (accept) begin
        front_q     <= front_d;
        count_q     <= count_d;
        status_q    <= status_d;
        fill_q      <= count_d;
        pop_ok_q    <= pop_ok_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp.valid             = rsp_valid_q;
  assign rsp.data.popped_value = pop_ok_q ? rdata_q : '0;
  assign rsp.data.status       = status_q;
  assign rsp.data.fill_count   = fill_q;

endmodule

### hw/rtl/dq_checker.sv
`include "double_ended_queue_assert.svh"

module dq_checker import dq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input rsp_t             rsp_data_i
);

  // A held result must not change while the receiver stalls.
  `DQ_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i), "result changed while stalled")

  // Every accepted request shows its result in the next cycle.
  `DQ_ASSERT(a_latency, req_valid_i && req_ready_i |=> rsp_valid_i, "no result after an accepted request")

  // A failed pop only happens on an empty queue and returns zero.
  `DQ_ASSERT(a_empty, rsp_valid_i && rsp_data_i.status == ST_EMPTY |-> rsp_data_i.fill_count == '0 && rsp_data_i.popped_value == '0, "bad empty result")

  // A failed push only happens on a full queue and returns zero.
  `DQ_ASSERT(a_full, rsp_valid_i && rsp_data_i.status == ST_FULL |-> rsp_data_i.fill_count == CNT_W'(DEPTH) && rsp_data_i.popped_value == '0, "bad full result")

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_data_i  (rsp.data)
);
